// ===== rtl/idll_pkg.sv =====
`timescale 1ns / 1ps

package idll_pkg;

    localparam int NODE_W     = 10;
    localparam int NODE_COUNT = 1024;
    localparam int MAX_ITEMS  = 1022;
    localparam int PC_W       = 5;

    localparam logic [NODE_W-1:0] HEAD_NODE = '0;
    localparam logic [NODE_W-1:0] TAIL_NODE = NODE_W'(MAX_ITEMS + 1);

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_UNLINK = 3'd1;
    localparam logic [2:0] OP_SWAP   = 3'd2;
    localparam logic [2:0] OP_TOGGLE = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_WAIT} t_state;

    typedef enum logic [3:0] {
        P_NONE, P_INS_EMPTY, P_INS_AFTER, P_INS_BEFORE, P_UNLINK,
        P_SWAP_TEST, P_SWAP_ADJ, P_SWAP_GEN, P_READ
    } t_prog;

    typedef enum logic [2:0] {
        U_END, U_READ, U_WRITE, U_BRANCH, U_SELX, U_EMIT
    } t_ukind;

    // FWD follows the walk direction: next links normally, prev links when reversed
    typedef enum logic [1:0] {TBL_NEXT, TBL_PREV, TBL_FWD} t_tbl;

    typedef enum logic [2:0] {
        OPD_A, OPD_B, OPD_HEAD, OPD_TAIL, OPD_T0, OPD_T1, OPD_T2, OPD_T3
    } t_opnd;

    typedef struct packed {
        t_ukind      kind;
        t_tbl        tbl;
        t_opnd       addr;
        t_opnd       val;
        logic [1:0]  dst;
    } t_uop;

    function automatic t_uop mk(t_ukind k, t_tbl t, t_opnd a, t_opnd v, logic [1:0] d);
        t_uop u;
        u.kind = k;
        u.tbl  = t;
        u.addr = a;
        u.val  = v;
        u.dst  = d;
        return u;
    endfunction

    function automatic t_uop rd(t_tbl t, t_opnd a, logic [1:0] d);
        return mk(U_READ, t, a, OPD_A, d);
    endfunction

    function automatic t_uop wr(t_tbl t, t_opnd a, t_opnd v);
        return mk(U_WRITE, t, a, v, 2'd0);
    endfunction

    function automatic t_uop ctl(t_ukind k);
        return mk(k, TBL_NEXT, OPD_A, OPD_A, 2'd0);
    endfunction

    // Step programs; each read lands in its temp register before the next step executes.
    function automatic t_uop ucode(t_prog p, logic [PC_W-1:0] pc);
        t_uop u;
        u = ctl(U_END);
        unique case (p)
            P_INS_EMPTY: begin
                case (pc)
                    5'd0: u = wr(TBL_NEXT, OPD_HEAD, OPD_A);
                    5'd1: u = wr(TBL_PREV, OPD_A, OPD_HEAD);
                    5'd2: u = wr(TBL_PREV, OPD_TAIL, OPD_A);
                    5'd3: u = wr(TBL_NEXT, OPD_A, OPD_TAIL);
                    default: u = ctl(U_END);
                endcase
            end
            P_INS_AFTER: begin
                case (pc)
                    5'd0: u = wr(TBL_PREV, OPD_A, OPD_B);
                    5'd1: u = rd(TBL_NEXT, OPD_B, 2'd0);
                    5'd2: u = wr(TBL_NEXT, OPD_A, OPD_T0);
                    5'd3: u = wr(TBL_NEXT, OPD_B, OPD_A);
                    5'd4: u = rd(TBL_NEXT, OPD_A, 2'd1);
                    5'd5: u = wr(TBL_PREV, OPD_T1, OPD_A);
                    default: u = ctl(U_END);
                endcase
            end
            P_INS_BEFORE: begin
                case (pc)
                    5'd0: u = wr(TBL_NEXT, OPD_A, OPD_B);
                    5'd1: u = rd(TBL_PREV, OPD_B, 2'd0);
                    5'd2: u = wr(TBL_PREV, OPD_A, OPD_T0);
                    5'd3: u = wr(TBL_PREV, OPD_B, OPD_A);
                    5'd4: u = rd(TBL_PREV, OPD_A, 2'd1);
                    5'd5: u = wr(TBL_NEXT, OPD_T1, OPD_A);
                    default: u = ctl(U_END);
                endcase
            end
            P_UNLINK: begin
                case (pc)
                    5'd0: u = rd(TBL_PREV, OPD_A, 2'd0);
                    5'd1: u = rd(TBL_NEXT, OPD_A, 2'd1);
                    5'd2: u = wr(TBL_NEXT, OPD_T0, OPD_T1);
                    5'd3: u = rd(TBL_NEXT, OPD_A, 2'd2);
                    5'd4: u = rd(TBL_PREV, OPD_A, 2'd3);
                    5'd5: u = wr(TBL_PREV, OPD_T2, OPD_T3);
                    default: u = ctl(U_END);
                endcase
            end
            P_SWAP_TEST: begin
                case (pc)
                    5'd0: u = rd(TBL_NEXT, OPD_A, 2'd0);
                    5'd1: u = rd(TBL_NEXT, OPD_B, 2'd1);
                    default: u = ctl(U_BRANCH);
                endcase
            end
            P_SWAP_ADJ: begin
                case (pc)
                    5'd0:  u = rd(TBL_PREV, OPD_A, 2'd0);
                    5'd1:  u = rd(TBL_NEXT, OPD_B, 2'd1);
                    5'd2:  u = rd(TBL_NEXT, OPD_T0, 2'd2);
                    5'd3:  u = rd(TBL_PREV, OPD_T1, 2'd3);
                    5'd4:  u = wr(TBL_NEXT, OPD_T0, OPD_T3);
                    5'd5:  u = wr(TBL_PREV, OPD_T1, OPD_T2);
                    5'd6:  u = rd(TBL_NEXT, OPD_B, 2'd0);
                    5'd7:  u = wr(TBL_NEXT, OPD_A, OPD_T0);
                    5'd8:  u = rd(TBL_PREV, OPD_A, 2'd0);
                    5'd9:  u = wr(TBL_PREV, OPD_B, OPD_T0);
                    5'd10: u = wr(TBL_PREV, OPD_A, OPD_B);
                    5'd11: u = wr(TBL_NEXT, OPD_B, OPD_A);
                    default: u = ctl(U_END);
                endcase
            end
            P_SWAP_GEN: begin
                case (pc)
                    5'd0:  u = rd(TBL_NEXT, OPD_A, 2'd0);
                    5'd1:  u = rd(TBL_NEXT, OPD_B, 2'd1);
                    5'd2:  u = rd(TBL_PREV, OPD_T0, 2'd2);
                    5'd3:  u = rd(TBL_PREV, OPD_T1, 2'd3);
                    5'd4:  u = wr(TBL_PREV, OPD_T0, OPD_T3);
                    5'd5:  u = wr(TBL_PREV, OPD_T1, OPD_T2);
                    5'd6:  u = rd(TBL_PREV, OPD_A, 2'd0);
                    5'd7:  u = rd(TBL_PREV, OPD_B, 2'd1);
                    5'd8:  u = rd(TBL_NEXT, OPD_T0, 2'd2);
                    5'd9:  u = rd(TBL_NEXT, OPD_T1, 2'd3);
                    5'd10: u = wr(TBL_NEXT, OPD_T0, OPD_T3);
                    5'd11: u = wr(TBL_NEXT, OPD_T1, OPD_T2);
                    5'd12: u = rd(TBL_NEXT, OPD_A, 2'd0);
                    5'd13: u = rd(TBL_NEXT, OPD_B, 2'd1);
                    5'd14: u = wr(TBL_NEXT, OPD_A, OPD_T1);
                    5'd15: u = wr(TBL_NEXT, OPD_B, OPD_T0);
                    5'd16: u = rd(TBL_PREV, OPD_A, 2'd0);
                    5'd17: u = rd(TBL_PREV, OPD_B, 2'd1);
                    5'd18: u = wr(TBL_PREV, OPD_A, OPD_T1);
                    5'd19: u = wr(TBL_PREV, OPD_B, OPD_T0);
                    default: u = ctl(U_END);
                endcase
            end
            P_READ: begin
                case (pc)
                    5'd0: u = rd(TBL_NEXT, OPD_HEAD, 2'd0);
                    5'd1: u = rd(TBL_PREV, OPD_TAIL, 2'd1);
                    5'd2: u = ctl(U_SELX);
                    5'd3: u = rd(TBL_FWD, OPD_T2, 2'd3);
                    default: u = ctl(U_EMIT);
                endcase
            end
            default: u = ctl(U_END);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/idll_ram.sv =====
`timescale 1ns / 1ps

module idll_ram (
    input  logic                           i_clk,
    input  logic                           i_we,
    input  logic [idll_pkg::NODE_W-1:0]    i_waddr,
    input  logic [idll_pkg::NODE_W-1:0]    i_wdata,
    input  logic                           i_re,
    input  logic [idll_pkg::NODE_W-1:0]    i_raddr,
    output logic [idll_pkg::NODE_W-1:0]    o_rdata
);

    logic [idll_pkg::NODE_W-1:0] mem [idll_pkg::NODE_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== rtl/indexed_doubly_linked_list.sv =====
`timescale 1ns / 1ps
// s_tready falls when a beat starts a program and rises again when the program ends;
// a read program can also be held by an output stall, and m_tvalid rises with s_tready.
// Toggle and ignored beats leave s_tready high. Beats are taken one at a time; each link
// read passes through an execute state and a wait state on the link tables.
// A read result is held in an output register while the next beat is already accepted.
// Reset (synchronous, active low): empty list, normal view, cursor at the front; link
// tables are not cleared, the two sentinel links live in flip-flops.
module indexed_doubly_linked_list (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // op[2:0], item_a[12:3], item_b[22:13],
                                   // place_after[23], into_empty[24], zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // item[9:0], zero fill
    output logic        m_tlast,   // is_last
    output logic        m_tuser    // list_empty
);

    localparam int W = idll_pkg::NODE_W;

    idll_pkg::t_state r_state, n_state;
    idll_pkg::t_prog  r_prog;
    logic [idll_pkg::PC_W-1:0] r_pc;
    logic             r_flip;      // swap the roles of item_a and item_b (adjacent swap)
    logic [W-1:0]     r_a, r_b, r_cur, r_head_next, r_tail_prev;
    logic [W-1:0]     r_t [4];
    logic             r_rev;
    logic             r_rd_next, r_rd_hit;
    logic [1:0]       r_rd_dst;
    logic             r_out_valid, r_out_last, r_out_empty;
    logic [W-1:0]     r_out_item;

    // Input beat fields
    logic [2:0]       in_op;
    logic [W-1:0]     in_a, in_b;
    logic             in_after, in_empty;

    assign in_op    = s_tdata[2:0];
    assign in_a     = s_tdata[12:3];
    assign in_b     = s_tdata[22:13];
    assign in_after = s_tdata[23];
    assign in_empty = s_tdata[24];

    logic accept;
    assign s_tready = (r_state == idll_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Decode an accepted beat into a step program
    logic a_ok, b_ok;
    idll_pkg::t_prog start_prog;

    assign a_ok = (in_a != '0) && (in_a <= W'(idll_pkg::MAX_ITEMS));
    assign b_ok = (in_b != '0) && (in_b <= W'(idll_pkg::MAX_ITEMS));

    always_comb begin
        start_prog = idll_pkg::P_NONE;
        unique case (in_op)
            idll_pkg::OP_INSERT: begin
                if (a_ok && in_empty) begin
                    start_prog = idll_pkg::P_INS_EMPTY;
                end else if (a_ok && b_ok) begin
                    start_prog = (in_after != r_rev) ? idll_pkg::P_INS_AFTER
                                                     : idll_pkg::P_INS_BEFORE;
                end
            end
            idll_pkg::OP_UNLINK: start_prog = a_ok ? idll_pkg::P_UNLINK : idll_pkg::P_NONE;
            idll_pkg::OP_SWAP:
                start_prog = (a_ok && b_ok) ? idll_pkg::P_SWAP_TEST : idll_pkg::P_NONE;
            idll_pkg::OP_READ:   start_prog = idll_pkg::P_READ;
            default:             start_prog = idll_pkg::P_NONE;
        endcase
    end

    // Current step and its operands
    idll_pkg::t_uop uop;
    assign uop = idll_pkg::ucode(r_prog, r_pc);

    function automatic logic [W-1:0] resolve(idll_pkg::t_opnd o);
        logic [W-1:0] v;
        unique case (o)
            idll_pkg::OPD_A:    v = r_flip ? r_b : r_a;
            idll_pkg::OPD_B:    v = r_flip ? r_a : r_b;
            idll_pkg::OPD_HEAD: v = idll_pkg::HEAD_NODE;
            idll_pkg::OPD_TAIL: v = idll_pkg::TAIL_NODE;
            idll_pkg::OPD_T0:   v = r_t[0];
            idll_pkg::OPD_T1:   v = r_t[1];
            idll_pkg::OPD_T2:   v = r_t[2];
            default:            v = r_t[3];
        endcase
        return v;
    endfunction

    logic         exec, use_next, is_rd, is_wr, hit, out_free, emit_fire;
    logic [W-1:0] addr_v, data_v, nq, pq, cap, x_sel, succ, walk_end;

    always_comb begin
        exec     = (r_state == idll_pkg::ST_EXEC);
        addr_v   = resolve(uop.addr);
        data_v   = resolve(uop.val);
        use_next = (uop.tbl == idll_pkg::TBL_NEXT) ||
                   ((uop.tbl == idll_pkg::TBL_FWD) && !r_rev);
        is_rd    = exec && (uop.kind == idll_pkg::U_READ);
        is_wr    = exec && (uop.kind == idll_pkg::U_WRITE);
        // The head's next and tail's prev entries are held in flip-flops
        hit      = use_next ? (addr_v == idll_pkg::HEAD_NODE)
                            : (addr_v == idll_pkg::TAIL_NODE);
        cap      = r_rd_next ? (r_rd_hit ? r_head_next : nq)
                             : (r_rd_hit ? r_tail_prev : pq);
        // A cursor on a sentinel restarts at the logical front
        x_sel    = ((r_cur != '0) && (r_cur <= W'(idll_pkg::MAX_ITEMS))) ? r_cur
                   : (r_rev ? r_t[1] : r_t[0]);
        succ     = r_t[3];
        walk_end = r_rev ? idll_pkg::HEAD_NODE : idll_pkg::TAIL_NODE;
        out_free = !r_out_valid || m_tready;
        emit_fire = exec && (uop.kind == idll_pkg::U_EMIT) && out_free;
    end

    idll_ram u_next (
        .i_clk   (i_clk),
        .i_we    (is_wr && use_next),
        .i_waddr (addr_v),
        .i_wdata (data_v),
        .i_re    (is_rd && use_next),
        .i_raddr (addr_v),
        .o_rdata (nq)
    );

    idll_ram u_prev (
        .i_clk   (i_clk),
        .i_we    (is_wr && !use_next),
        .i_waddr (addr_v),
        .i_wdata (data_v),
        .i_re    (is_rd && !use_next),
        .i_raddr (addr_v),
        .o_rdata (pq)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            idll_pkg::ST_IDLE: begin
                if (accept && (start_prog != idll_pkg::P_NONE)) begin
                    n_state = idll_pkg::ST_EXEC;
                end
            end
            idll_pkg::ST_EXEC: begin
                priority case (uop.kind)
                    idll_pkg::U_READ: n_state = idll_pkg::ST_WAIT;
                    idll_pkg::U_END:  n_state = idll_pkg::ST_IDLE;
                    idll_pkg::U_EMIT: n_state = out_free ? idll_pkg::ST_IDLE
                                                         : idll_pkg::ST_EXEC;
                    default:          n_state = idll_pkg::ST_EXEC;
                endcase
            end
            default: n_state = idll_pkg::ST_EXEC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= idll_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control: program and program counter, flip and view flags, cursor, sentinel links, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog      <= idll_pkg::P_NONE;
            r_pc        <= '0;
            r_flip      <= 1'b0;
            r_rev       <= 1'b0;
            r_cur       <= idll_pkg::HEAD_NODE;
            r_head_next <= idll_pkg::TAIL_NODE;
            r_tail_prev <= idll_pkg::HEAD_NODE;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_prog <= start_prog;
                r_pc   <= '0;
                r_flip <= 1'b0;
                if (in_op == idll_pkg::OP_TOGGLE) begin
                    r_rev <= ~r_rev;
                    r_cur <= idll_pkg::HEAD_NODE;
                end
            end
            if (exec) begin
                priority case (uop.kind)
                    idll_pkg::U_READ, idll_pkg::U_WRITE, idll_pkg::U_SELX:
                        r_pc <= r_pc + 1'b1;
                    idll_pkg::U_BRANCH: begin
                        r_pc <= '0;
                        if (r_t[0] == r_b) begin
                            r_prog <= idll_pkg::P_SWAP_ADJ;
                        end else if (r_t[1] == r_a) begin
                            r_prog <= idll_pkg::P_SWAP_ADJ;
                            r_flip <= 1'b1;
                        end else begin
                            r_prog <= idll_pkg::P_SWAP_GEN;
                        end
                    end
                    default: r_pc <= r_pc;
                endcase
            end
            if (is_wr && use_next && hit) begin
                r_head_next <= data_v;
            end
            if (is_wr && !use_next && hit) begin
                r_tail_prev <= data_v;
            end
            if (emit_fire) begin
                r_out_valid <= 1'b1;
                if (r_t[0] == idll_pkg::TAIL_NODE || succ == walk_end) begin
                    r_cur <= idll_pkg::HEAD_NODE;
                end else begin
                    r_cur <= succ;
                end
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: operands, temps, read tags, result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= in_a;
            r_b <= in_b;
        end
        if (is_rd) begin
            r_rd_next <= use_next;
            r_rd_hit  <= hit;
            r_rd_dst  <= uop.dst;
        end
        if (r_state == idll_pkg::ST_WAIT) begin
            r_t[r_rd_dst] <= cap;
        end
        if (exec && uop.kind == idll_pkg::U_SELX) begin
            r_t[2] <= x_sel;
        end
        if (emit_fire) begin
            if (r_t[0] == idll_pkg::TAIL_NODE) begin
                r_out_item  <= '0;
                r_out_last  <= 1'b1;
                r_out_empty <= 1'b1;
            end else begin
                r_out_item  <= r_t[2];
                r_out_last  <= (succ == walk_end);
                r_out_empty <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'b0, r_out_item};
    assign m_tlast  = r_out_last;
    assign m_tuser  = r_out_empty;

    // An empty-list beat always carries item zero and ends the order
    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser |-> (m_tdata[9:0] == '0) && m_tlast)
        else $error("empty-list beat with nonzero item or no last");

    // A table read's wait state always returns to execution on the next cycle
    a_wait_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == idll_pkg::ST_WAIT |=> r_state == idll_pkg::ST_EXEC)
        else $error("read wait did not return to execution");

    // A read request starts a program
    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (in_op == idll_pkg::OP_READ) |=> r_state == idll_pkg::ST_EXEC)
        else $error("read request was dropped");

endmodule
